[src/sbe_pkg.sv]
// Shared types and constants for the stack bytecode executor.
// Holds opcodes, status codes, ALU request/response and the channel words.
// No dependencies.
package sbe_pkg;

    localparam int STACK_DEPTH_DEF  = 256;
    localparam int REG_COUNT_DEF    = 16;
    localparam int PROGRAM_SIZE_DEF = 65536;

    // opcodes
    localparam logic [3:0] OP_NOP   = 4'd0;
    localparam logic [3:0] OP_PUSH  = 4'd1;
    localparam logic [3:0] OP_POP   = 4'd2;
    localparam logic [3:0] OP_LOAD  = 4'd3;
    localparam logic [3:0] OP_STORE = 4'd4;
    localparam logic [3:0] OP_JMP   = 4'd5;
    localparam logic [3:0] OP_JZ    = 4'd6;
    localparam logic [3:0] OP_JNZ   = 4'd7;
    localparam logic [3:0] OP_ADD   = 4'd8;
    localparam logic [3:0] OP_SUB   = 4'd9;
    localparam logic [3:0] OP_MUL   = 4'd10;
    localparam logic [3:0] OP_DIV   = 4'd11;
    localparam logic [3:0] OP_PRINT = 4'd12;
    localparam logic [3:0] OP_STOP  = 4'd13;

    // status codes
    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_STOP    = 4'd1;
    localparam logic [3:0] ST_OVER    = 4'd2;
    localparam logic [3:0] ST_UNDER   = 4'd3;
    localparam logic [3:0] ST_BADREG  = 4'd4;
    localparam logic [3:0] ST_BADTGT  = 4'd5;
    localparam logic [3:0] ST_DIV0    = 4'd6;
    localparam logic [3:0] ST_INVALID = 4'd7;
    localparam logic [3:0] ST_HALTED  = 4'd8;

    // instruction lengths in bytes
    localparam logic [15:0] LEN_ONE  = 16'd1;
    localparam logic [15:0] LEN_MEM  = 16'd2;
    localparam logic [15:0] LEN_JUMP = 16'd3;
    localparam logic [15:0] LEN_PUSH = 16'd5;

    // ALU operations
    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_SUB = 2'd1;
    localparam logic [1:0] ALU_MUL = 2'd2;
    localparam logic [1:0] ALU_DIV = 2'd3;

    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } t_alu_rsp;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] push_value;
        logic [15:0]        operand_index;
    } t_in_word;

    typedef struct packed {
        logic [3:0]         status;
        logic [15:0]        next_address;
        logic               print_valid;
        logic signed [31:0] print_value;
    } t_out_word;

endpackage

[src/sbe_alu.sv]
// Iterative 32-bit ALU: add, sub, shift-add multiply, restoring signed divide.
// One 33-bit adder serves every step. Uses sbe_pkg.
module sbe_alu
    import sbe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    localparam int STEPS = 32;
    localparam int CW    = $clog2(STEPS);

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_ADD  = 3'd1;
    localparam logic [2:0] A_MUL  = 3'd2;
    localparam logic [2:0] A_NEGA = 3'd3;
    localparam logic [2:0] A_NEGB = 3'd4;
    localparam logic [2:0] A_DIV  = 3'd5;
    localparam logic [2:0] A_FIX  = 3'd6;

    logic [2:0]    r_state;
    logic [1:0]    r_op;
    logic [31:0]   r_a;
    logic [31:0]   r_b;
    logic [31:0]   r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_neg;
    logic          r_done;
    logic [31:0]   r_res;

    logic [32:0] ad_x;
    logic [32:0] ad_y;
    logic        ad_ci;
    logic [33:0] ad_sum;
    logic        last;

    assign ad_sum = {1'b0, ad_x} + {1'b0, ad_y} + 34'(ad_ci);
    assign last   = (r_cnt == CW'(STEPS - 1));

    // operand select for the shared adder
    always_comb begin
        ad_x  = {1'b0, r_a};
        ad_y  = '0;
        ad_ci = 1'b0;
        unique case (r_state)
            A_ADD: begin
                ad_y  = (r_op == ALU_SUB) ? {1'b0, ~r_b} : {1'b0, r_b};
                ad_ci = (r_op == ALU_SUB);
            end
            A_MUL: begin
                ad_x = {1'b0, r_acc};
                ad_y = {1'b0, r_a};
            end
            A_NEGA, A_FIX: begin
                ad_x  = {1'b0, ~r_a};
                ad_ci = 1'b1;
            end
            A_NEGB: begin
                ad_x  = {1'b0, ~r_b};
                ad_ci = 1'b1;
            end
            A_DIV: begin
                // trial subtract of divisor from shifted remainder
                ad_x  = {r_acc, r_a[31]};
                ad_y  = ~{1'b0, r_b};
                ad_ci = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_op  <= i_req.op;
                        r_a   <= i_req.a;
                        r_b   <= i_req.b;
                        r_acc <= '0;
                        r_cnt <= '0;
                        r_neg <= i_req.a[31] ^ i_req.b[31];
                        unique case (i_req.op)
                            ALU_ADD, ALU_SUB: r_state <= A_ADD;
                            ALU_MUL:          r_state <= A_MUL;
                            ALU_DIV:          r_state <= A_NEGA;
                            default:          r_state <= A_IDLE;
                        endcase
                    end
                end
                A_ADD: begin
                    r_res   <= ad_sum[31:0];
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                A_MUL: begin
                    if (r_b[0]) begin
                        r_acc <= ad_sum[31:0];
                    end
                    r_a   <= {r_a[30:0], 1'b0};
                    r_b   <= {1'b0, r_b[31:1]};
                    r_cnt <= r_cnt + CW'(1);
                    if (last) begin
                        r_res   <= r_b[0] ? ad_sum[31:0] : r_acc;
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end
                end
                A_NEGA: begin
                    if (r_a[31]) begin
                        r_a <= ad_sum[31:0];
                    end
                    r_state <= A_NEGB;
                end
                A_NEGB: begin
                    if (r_b[31]) begin
                        r_b <= ad_sum[31:0];
                    end
                    r_state <= A_DIV;
                end
                A_DIV: begin
                    // carry out set means no borrow: quotient bit is 1
                    r_acc <= ad_sum[33] ? ad_sum[31:0] : {r_acc[30:0], r_a[31]};
                    r_a   <= {r_a[30:0], ad_sum[33]};
                    r_cnt <= r_cnt + CW'(1);
                    if (last) begin
                        r_state <= A_FIX;
                    end
                end
                A_FIX: begin
                    r_res   <= r_neg ? ad_sum[31:0] : r_a;
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

[src/stack_bytecode_executor.sv]
// Stack bytecode executor: executes one pre-fetched instruction per input word.
// Input channel: i_in_valid / o_in_stall, word i_in_word (mode, immediate, operand).
// Output channel: o_out_valid / i_out_stall, word o_out_word (status, next
// address, print flag and value). Every accepted word yields one output word.
// Instructions run one at a time under a small sequencer; o_in_stall is high
// from acceptance until the result is loaded into the output register.
// Decode-only results (nop/push/pop/load/jmp/stop, the halted status and the
// faults found at decode) go from decode to output; store/jz/jnz/print also
// pass the top-of-stack read, divide by zero both stack reads, and add/sub/mul/div
// both reads and then the ALU; the divide and multiply iterate 32 steps on the shared ALU adder.
// The next word can be accepted in the cycle after the result loads, so the
// block takes no new word until it is through with the last one.
// Stack reads go through a single registered memory port, one entry a cycle.
// A stalled output word holds; the block waits in its output state until the
// output register frees, then accepts the next word.
// Reset clears the instruction pointer, stack depth, halt flag and register
// file; stack contents are left as they are. Stop or any fault
// halts execution: later words report the halted status until reset.
// Uses sbe_pkg and sbe_alu.
module stack_bytecode_executor
    import sbe_pkg::*;
#(
    parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
    parameter int REG_COUNT    = REG_COUNT_DEF,
    parameter int PROGRAM_SIZE = PROGRAM_SIZE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_RDB    = 3'd2;
    localparam logic [2:0] S_RDA    = 3'd3;
    localparam logic [2:0] S_ALU    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [15:0]   r_ip;
    logic [DW-1:0] r_depth, n_depth;
    logic          r_halted;
    logic [31:0]   r_regs [REG_COUNT];
    logic [3:0]    r_op;
    logic [31:0]   r_imm;
    logic [15:0]   r_idx;
    logic [31:0]   r_b;
    t_out_word     r_res;
    logic          r_out_valid;
    t_out_word     r_out_word;

    logic [31:0]   mem [STACK_DEPTH];
    logic [31:0]   r_mem_q;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;

    logic          reg_we;
    logic [RW-1:0] ri;
    logic          fin;
    t_out_word     fin_word;
    logic          out_load;
    logic          in_acc;

    logic [AW-1:0] dm1, dm2;
    logic          full, empty, lt2, bad_reg, bad_tgt, cond;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    sbe_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    assign in_acc  = i_in_valid && !o_in_stall;
    assign ri      = r_idx[RW-1:0];
    assign dm1     = AW'(r_depth - DW'(1));
    assign dm2     = AW'(r_depth - DW'(2));
    assign full    = (r_depth >= DW'(STACK_DEPTH));
    assign empty   = (r_depth == '0);
    assign lt2     = (r_depth < DW'(2));
    assign bad_reg = ({1'b0, r_idx} >= 17'(REG_COUNT));
    assign bad_tgt = ({1'b0, r_idx} >= 17'(PROGRAM_SIZE));
    assign cond    = ((r_op == OP_JZ) == (r_mem_q == '0));

    always_comb begin
        n_state  = r_state;
        n_depth  = r_depth;
        fin      = 1'b0;
        fin_word = '{status: ST_OK, next_address: r_ip, print_valid: 1'b0,
                     print_value: '0};
        mem_we   = 1'b0;
        mem_wa   = AW'(r_depth);
        mem_wd   = r_imm;
        reg_we   = 1'b0;
        rd_addr  = dm1;
        out_load = 1'b0;
        alu_req.start = 1'b0;
        alu_req.a     = r_mem_q;
        alu_req.b     = r_b;
        unique case (r_op)
            OP_ADD:  alu_req.op = ALU_ADD;
            OP_SUB:  alu_req.op = ALU_SUB;
            OP_MUL:  alu_req.op = ALU_MUL;
            default: alu_req.op = ALU_DIV;
        endcase

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                fin = 1'b1;
                if (r_halted) begin
                    fin_word.status = ST_HALTED;
                end else begin
                    unique case (r_op)
                        OP_NOP: fin_word.next_address = r_ip + LEN_ONE;
                        OP_PUSH: begin
                            if (full) begin
                                fin_word.status = ST_OVER;
                            end else begin
                                mem_we  = 1'b1;
                                n_depth = r_depth + DW'(1);
                                fin_word.next_address = r_ip + LEN_PUSH;
                            end
                        end
                        OP_POP: begin
                            if (empty) begin
                                fin_word.status = ST_UNDER;
                            end else begin
                                n_depth = r_depth - DW'(1);
                                fin_word.next_address = r_ip + LEN_ONE;
                            end
                        end
                        OP_LOAD: begin
                            if (bad_reg) begin
                                fin_word.status = ST_BADREG;
                            end else if (full) begin
                                fin_word.status = ST_OVER;
                            end else begin
                                mem_we  = 1'b1;
                                mem_wd  = r_regs[ri];
                                n_depth = r_depth + DW'(1);
                                fin_word.next_address = r_ip + LEN_MEM;
                            end
                        end
                        OP_STORE: begin
                            if (bad_reg) begin
                                fin_word.status = ST_BADREG;
                            end else if (empty) begin
                                fin_word.status = ST_UNDER;
                            end else begin
                                fin = 1'b0;
                            end
                        end
                        OP_JMP: begin
                            if (bad_tgt) begin
                                fin_word.status = ST_BADTGT;
                            end else begin
                                fin_word.next_address = r_idx;
                            end
                        end
                        OP_JZ, OP_JNZ: begin
                            if (bad_tgt) begin
                                fin_word.status = ST_BADTGT;
                            end else if (empty) begin
                                fin_word.status = ST_UNDER;
                            end else begin
                                fin = 1'b0;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                            if (lt2) begin
                                fin_word.status = ST_UNDER;
                            end else begin
                                fin = 1'b0;
                            end
                        end
                        OP_PRINT: begin
                            if (empty) begin
                                fin_word.status = ST_UNDER;
                            end else begin
                                fin = 1'b0;
                            end
                        end
                        OP_STOP: fin_word.status = ST_STOP;
                        default: fin_word.status = ST_INVALID;
                    endcase
                end
                n_state = fin ? S_OUT : S_RDB;
            end
            S_RDB: begin
                // r_mem_q holds the top of stack
                rd_addr = dm2;
                fin     = 1'b1;
                unique case (r_op)
                    OP_STORE: begin
                        reg_we  = 1'b1;
                        n_depth = r_depth - DW'(1);
                        fin_word.next_address = r_ip + LEN_MEM;
                    end
                    OP_JZ, OP_JNZ: begin
                        n_depth = r_depth - DW'(1);
                        fin_word.next_address = cond ? r_idx : r_ip + LEN_JUMP;
                    end
                    OP_PRINT: begin
                        n_depth = r_depth - DW'(1);
                        fin_word.print_valid  = 1'b1;
                        fin_word.print_value  = r_mem_q;
                        fin_word.next_address = r_ip + LEN_ONE;
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: fin = 1'b0;
                    default: fin_word.status = ST_INVALID;
                endcase
                n_state = fin ? S_OUT : S_RDA;
            end
            S_RDA: begin
                // r_mem_q holds the second entry, r_b the top
                if ((r_op == OP_DIV) && (r_b == '0)) begin
                    fin             = 1'b1;
                    fin_word.status = ST_DIV0;
                    n_state         = S_OUT;
                end else begin
                    alu_req.start = 1'b1;
                    n_state       = S_ALU;
                end
            end
            S_ALU: begin
                if (alu_rsp.done) begin
                    fin     = 1'b1;
                    mem_we  = 1'b1;
                    mem_wa  = dm2;
                    mem_wd  = alu_rsp.result;
                    n_depth = r_depth - DW'(1);
                    fin_word.next_address = r_ip + LEN_ONE;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ip        <= '0;
            r_depth     <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            if (fin) begin
                r_ip <= fin_word.next_address;
                if (fin_word.status != ST_OK) begin
                    r_halted <= 1'b1;
                end
            end
            if (reg_we) begin
                r_regs[ri] <= r_mem_q;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= i_in_word.mode;
            r_imm <= i_in_word.push_value;
            r_idx <= i_in_word.operand_index;
        end
        if (r_state == S_RDB) begin
            r_b <= r_mem_q;
        end
        if (fin) begin
            r_res <= fin_word;
        end
        if (out_load) begin
            r_out_word <= r_res;
        end
    end

    // data stack memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mem_q <= mem[rd_addr];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[sim/tb_top.sv]
// Testbench for stack_bytecode_executor: drives instruction words, predicts each
// result word from a model of the stack machine, and checks them in order.
// Depends on sbe_pkg and the stack_bytecode_executor RTL.
module tb_top;
    import sbe_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 10;

    localparam logic [3:0] OP_BAD_LO = 4'd14;
    localparam logic [3:0] OP_BAD_HI = 4'd15;

    typedef enum int {
        HALT_STOP, HALT_OVER, HALT_BADREG_LOAD, HALT_BADREG_STORE, HALT_UNDER_POP,
        HALT_UNDER_ARITH, HALT_UNDER_JUMP, HALT_DIV0, HALT_INVALID
    } t_halt_kind;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;

    // machine state as the block should hold it
    logic [15:0] ip       = '0;
    int          sp_depth = 0;
    bit          halted   = 1'b0;
    logic [31:0] stack_mem [STACK_DEPTH_DEF];
    logic [31:0] reg_mem   [REG_COUNT_DEF] = '{default: '0};

    t_out_word pending_results [$];
    int        err_cnt      = 0;
    int        burst_left   = 0;
    int        hold_req_cnt = 0;
    int        hold_ack_cnt = 0;
    int        hold_left    = 0;
    int        stall_mode   = 0;
    int        phase_left   = 0;

    stack_bytecode_executor i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] quot_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? 32'd0 - a : a;
        mb = b[31] ? 32'd0 - b : b;
        q  = ma / mb;
        return (a[31] ^ b[31]) ? 32'd0 - q : q;
    endfunction

    // Executes one instruction on the local machine state, returns its result word.
    function automatic t_out_word exec_instr(input t_in_word w);
        t_out_word   r;
        logic [3:0]  st;
        logic [15:0] nxt;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] res;
        r   = '0;
        st  = ST_OK;
        nxt = ip;
        res = '0;
        if (halted) begin
            st = ST_HALTED;
        end else begin
            case (w.mode)
                OP_NOP: nxt = ip + LEN_ONE;
                OP_PUSH: begin
                    if (sp_depth >= STACK_DEPTH_DEF) begin
                        st = ST_OVER;
                    end else begin
                        stack_mem[sp_depth] = w.push_value;
                        sp_depth++;
                        nxt = ip + LEN_PUSH;
                    end
                end
                OP_POP: begin
                    if (sp_depth == 0) begin
                        st = ST_UNDER;
                    end else begin
                        sp_depth--;
                        nxt = ip + LEN_ONE;
                    end
                end
                OP_LOAD: begin
                    if (int'(w.operand_index) >= REG_COUNT_DEF) begin
                        st = ST_BADREG;
                    end else if (sp_depth >= STACK_DEPTH_DEF) begin
                        st = ST_OVER;
                    end else begin
                        stack_mem[sp_depth] = reg_mem[w.operand_index];
                        sp_depth++;
                        nxt = ip + LEN_MEM;
                    end
                end
                OP_STORE: begin
                    if (int'(w.operand_index) >= REG_COUNT_DEF) begin
                        st = ST_BADREG;
                    end else if (sp_depth == 0) begin
                        st = ST_UNDER;
                    end else begin
                        sp_depth--;
                        reg_mem[w.operand_index] = stack_mem[sp_depth];
                        nxt = ip + LEN_MEM;
                    end
                end
                OP_JMP: begin
                    if (int'(w.operand_index) >= PROGRAM_SIZE_DEF) st = ST_BADTGT;
                    else nxt = w.operand_index;
                end
                OP_JZ, OP_JNZ: begin
                    if (int'(w.operand_index) >= PROGRAM_SIZE_DEF) begin
                        st = ST_BADTGT;
                    end else if (sp_depth == 0) begin
                        st = ST_UNDER;
                    end else begin
                        sp_depth--;
                        a = stack_mem[sp_depth];
                        if ((w.mode == OP_JZ) == (a == '0)) nxt = w.operand_index;
                        else nxt = ip + LEN_JUMP;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                    if (sp_depth < 2) begin
                        st = ST_UNDER;
                    end else begin
                        // second entry from the top is the left operand
                        b = stack_mem[sp_depth - 1];
                        a = stack_mem[sp_depth - 2];
                        case (w.mode)
                            OP_ADD: res = a + b;
                            OP_SUB: res = a - b;
                            OP_MUL: res = a * b;
                            default: begin
                                if (b == '0) st = ST_DIV0;
                                else res = quot_trunc(a, b);
                            end
                        endcase
                        if (st == ST_OK) begin
                            sp_depth--;
                            stack_mem[sp_depth - 1] = res;
                            nxt = ip + LEN_ONE;
                        end
                    end
                end
                OP_PRINT: begin
                    if (sp_depth == 0) begin
                        st = ST_UNDER;
                    end else begin
                        sp_depth--;
                        r.print_valid = 1'b1;
                        r.print_value = stack_mem[sp_depth];
                        nxt = ip + LEN_ONE;
                    end
                end
                OP_STOP: st = ST_STOP;
                default: st = ST_INVALID;
            endcase
            // faults and stop leave ip on the current instruction
            if (st != ST_OK) begin
                halted = 1'b1;
                nxt    = ip;
            end
            ip = nxt;
        end
        r.status       = st;
        r.next_address = ip;
        return r;
    endfunction

    function automatic logic [31:0] rand_imm();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    default: return 32'd1;
                endcase
            end
            2, 3: return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom();
        endcase
    endfunction

    // Random instruction that cannot fault in the current state; pushes only below cap.
    function automatic t_in_word pick_legal(input int cap);
        t_in_word w;
        bit       ok;
        w.push_value    = rand_imm();
        w.operand_index = 16'($urandom());
        do begin
            w.mode = 4'($urandom_range(0, OP_PRINT));
            case (w.mode)
                OP_PUSH:  ok = sp_depth < cap;
                OP_LOAD:  ok = sp_depth < cap;
                OP_STORE: ok = sp_depth >= 1;
                OP_POP, OP_PRINT, OP_JZ, OP_JNZ: ok = sp_depth >= 1;
                OP_ADD, OP_SUB, OP_MUL: ok = sp_depth >= 2;
                OP_DIV: ok = sp_depth >= 2 && stack_mem[sp_depth - 1] != '0;
                default: ok = 1'b1;
            endcase
        end while (!ok);
        if (w.mode == OP_LOAD || w.mode == OP_STORE)
            w.operand_index = 16'($urandom_range(0, REG_COUNT_DEF - 1));
        return w;
    endfunction

    // Offers one word in bursts with random gaps; predicts it once accepted.
    task automatic send_word(input t_in_word w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(exec_instr(w));
    endtask

    task automatic send_op(input logic [3:0] op, input logic [31:0] imm,
                           input logic [15:0] idx);
        t_in_word w;
        w.mode          = op;
        w.push_value    = imm;
        w.operand_index = idx;
        send_word(w);
    endtask

    task automatic fill_stack();
        while (sp_depth < STACK_DEPTH_DEF) begin
            if ($urandom_range(0, 3) == 0)
                send_op(OP_LOAD, rand_imm(), 16'($urandom_range(0, REG_COUNT_DEF - 1)));
            else
                send_op(OP_PUSH, rand_imm(), 16'($urandom()));
        end
    endtask

    task automatic drain_stack();
        while (sp_depth > 0) send_word(pick_legal(0));
    endtask

    task automatic test_directed();
        send_op(OP_LOAD, rand_imm(), 16'd0);      // registers read zero after reset
        send_op(OP_PRINT, 32'hffff_ffff, 16'hffff);
        send_op(OP_NOP, 32'hffff_ffff, 16'hffff);
        send_op(OP_PUSH, 32'h7fff_ffff, 16'd0);
        send_op(OP_PUSH, 32'd1, 16'd0);
        send_op(OP_ADD, 32'd0, 16'd0);            // wraps to the most negative value
        send_op(OP_STORE, 32'd0, 16'd15);
        send_op(OP_LOAD, 32'd0, 16'd15);
        send_op(OP_PRINT, 32'd0, 16'd0);
        send_op(OP_PUSH, 32'h8000_0000, 16'd0);
        send_op(OP_PUSH, 32'hffff_ffff, 16'd0);
        send_op(OP_DIV, 32'd0, 16'd0);            // most negative over -1
        send_op(OP_PRINT, 32'd0, 16'd0);
        send_op(OP_PUSH, -32'sd7, 16'd0);
        send_op(OP_PUSH, 32'd2, 16'd0);
        send_op(OP_DIV, 32'd0, 16'd0);
        send_op(OP_PUSH, 32'd7, 16'd0);
        send_op(OP_PUSH, -32'sd2, 16'd0);
        send_op(OP_DIV, 32'd0, 16'd0);
        send_op(OP_SUB, 32'd0, 16'd0);
        send_op(OP_JZ, 32'd0, 16'h1234);          // zero on top: taken
        send_op(OP_PUSH, 32'h0001_0000, 16'd0);
        send_op(OP_PUSH, 32'h0001_0000, 16'd0);
        send_op(OP_MUL, 32'd0, 16'd0);            // product wraps to zero
        send_op(OP_JNZ, 32'd0, 16'h0000);         // not taken
        send_op(OP_PUSH, 32'd3, 16'd0);
        send_op(OP_JZ, 32'd0, 16'h5555);          // not taken
        send_op(OP_PUSH, 32'd5, 16'd0);
        send_op(OP_JNZ, 32'd0, 16'habcd);         // taken
        send_op(OP_JMP, 32'd0, 16'hffff);
        send_op(OP_PUSH, 32'h1234_5678, 16'd0);   // address wraps past the top
        send_op(OP_POP, 32'd0, 16'd0);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) send_word(pick_legal(((i / 100) % 2) ? 6 : 32));
    endtask

    // Receiver holds off while the sender keeps offering words.
    task automatic test_pressure();
        hold_req_cnt++;
        repeat (30) send_word(pick_legal(16));
    endtask

    task automatic test_stack_full();
        fill_stack();
        send_op(OP_NOP, rand_imm(), 16'($urandom()));
        drain_stack();
    endtask

    // One halting event (only one reset per run), then words that must report the halted status.
    task automatic test_halt();
        t_halt_kind kind;
        kind = t_halt_kind'($urandom_range(0, HALT_INVALID));
        case (kind)
            HALT_STOP: send_op(OP_STOP, rand_imm(), 16'($urandom()));
            HALT_OVER: begin
                fill_stack();
                send_op(($urandom_range(0, 1) != 0) ? OP_PUSH : OP_LOAD, rand_imm(), 16'd0);
            end
            HALT_BADREG_LOAD: begin
                // register check comes before the overflow check
                fill_stack();
                send_op(OP_LOAD, rand_imm(), 16'($urandom_range(REG_COUNT_DEF, 65535)));
            end
            HALT_BADREG_STORE: begin
                drain_stack();
                send_op(OP_STORE, rand_imm(), 16'($urandom_range(REG_COUNT_DEF, 65535)));
            end
            HALT_UNDER_POP: begin
                drain_stack();
                send_op(($urandom_range(0, 1) != 0) ? OP_POP : OP_PRINT, rand_imm(), 16'd0);
            end
            HALT_UNDER_ARITH: begin
                drain_stack();
                send_op(OP_PUSH, rand_imm(), 16'd0);
                send_op(4'(OP_ADD + $urandom_range(0, 3)), rand_imm(), 16'd0);
            end
            HALT_UNDER_JUMP: begin
                drain_stack();
                send_op(($urandom_range(0, 1) != 0) ? OP_JZ : OP_JNZ, rand_imm(),
                        16'($urandom()));
            end
            HALT_DIV0: begin
                send_op(OP_PUSH, rand_imm(), 16'd0);
                send_op(OP_PUSH, 32'd0, 16'd0);
                send_op(OP_DIV, rand_imm(), 16'd0);
            end
            default: send_op(($urandom_range(0, 1) != 0) ? OP_BAD_HI : OP_BAD_LO,
                             rand_imm(), 16'($urandom()));
        endcase
        repeat (20) send_op(4'($urandom()), $urandom(), 16'($urandom()));
    endtask

    task automatic report_error(input string what, input t_out_word exp_w,
                                input t_out_word got_w);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("%s: exp st %0d addr %h pv %b val %h, got st %0d addr %h pv %b val %h",
                     what, exp_w.status, exp_w.next_address, exp_w.print_valid,
                     exp_w.print_value, got_w.status, got_w.next_address,
                     got_w.print_valid, got_w.print_value);
    endtask

    // result checker
    always @(posedge clk) begin
        t_out_word exp_w;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_error("unexpected word", '0, out_word);
            end else begin
                exp_w = pending_results.pop_front();
                if (out_word.status !== exp_w.status ||
                    out_word.next_address !== exp_w.next_address ||
                    out_word.print_valid !== exp_w.print_valid ||
                    out_word.print_value !== exp_w.print_value)
                    report_error("mismatch", exp_w, out_word);
            end
        end
    end

    // receiver stall pattern, with an occasional long hold-off on request
    always @(posedge clk) begin
        if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left    <= HOLD_CYCLES;
            out_stall    <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
            if (phase_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                phase_left <= $urandom_range(20, 200);
            end else begin
                phase_left <= phase_left - 1;
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
            else idle++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(150);
        test_pressure();
        test_stack_full();
        test_halt();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
